// ===== rtl/tfs_pkg.sv =====
`default_nettype none

package tfs_pkg;

	// Raw conversion code that flags a failed ADC read.
	localparam logic [15:0] ADC_INVALID      = 16'hFFFF;
	// Ceiling of the unsigned throttle level.
	localparam logic [15:0] LEVEL_SAT        = 16'hFFFF;
	// Limits of the signed torque reference, in two's complement.
	localparam logic [15:0] TORQUE_POS_LIMIT = 16'h7FFF;
	localparam logic [15:0] TORQUE_NEG_LIMIT = 16'h8000;

	// The shared divider yields a 16-bit quotient, one bit per step.
	localparam int unsigned DIV_STEPS = 16;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_BW     = 3'd0,
		REG_THR_OFFSET    = 3'd1,
		REG_THR_SLOPE     = 3'd2,
		REG_THR_DIVISOR   = 3'd3,
		REG_TQ_OFFSET     = 3'd4,
		REG_TQ_SLOPE      = 3'd5,
		REG_TQ_DIVISOR    = 3'd6,
		REG_DETECT_THRESH = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] bw_rise;
		logic [15:0] bw_fall;
		logic [15:0] thr_offset;
		logic [14:0] thr_slope;
		logic [15:0] thr_divisor;
		logic [15:0] tq_offset;
		logic [15:0] tq_slope;     // two's complement
		logic [15:0] tq_divisor;
		logic [15:0] detect_thresh;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] rem_init;
		logic [15:0] low_init;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic        pressed;
		logic [15:0] torque_reference;
		logic [15:0] throttle_level;
		logic [15:0] filtered_level;
	} result_t;

	// A divisor or bandwidth of zero behaves as one.
	function automatic logic [15:0] nonzero16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/throttle_filter_scale_core.sv =====
`default_nettype none

// Throttle conditioning core. Each beat on the slave side carries one raw
// 16-bit throttle conversion; the core smooths it with an asymmetric
// first-order low-pass (rising or falling bandwidth, chosen by whether the
// sample is above the running average), then scales the offset-removed level
// into a throttle level saturated at 65535, a signed torque reference
// saturated to the 16-bit range, and a pressed flag. A sample of 0xFFFF is
// treated as a failed conversion and leaves the average untouched. One sample
// is processed at a time: a single 16x16 multiplier and a radix-2 divider
// that produces one quotient bit per cycle are shared by all three stages.
// A valid sample passes from acceptance through a multiply, a load and a
// division in each of the filter, throttle and torque stages, then a final
// state hands the result to the output register; the next sample is accepted
// in the cycle after the hand-over at the earliest. A throttle or torque whose
// quotient would reach 65536 saturates and skips its division; an invalid
// sample skips the filter stage entirely. The hand-over waits while the output
// register still holds a beat that the downstream side has not taken; otherwise
// the next sample can be accepted while the previous result still waits there.
// Configuration writes take effect at once and should only be issued while
// the core is idle.
module throttle_filter_scale_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [15:0]                          s_tdata,  // [15:0] adc_sample

	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [15:0] filtered_level, [31:16] throttle_level, [47:32] torque_reference,
	// [48] pressed, [55:49] zero
	output logic [55:0]                               m_tdata,

	input  wire logic                                 cfg_wr_en,
	input  wire logic [tfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tfs_pkg::CFG_DATA_W-1:0]       cfg_data
);

	tfs_pkg::cfg_t      cfg;
	tfs_pkg::div_req_t  div_req;
	tfs_pkg::div_rsp_t  div_rsp;
	tfs_pkg::result_t   res;
	logic [15:0]        div_divisor;
	logic               res_valid;
	logic               out_free;

	logic               out_valid_q;
	tfs_pkg::result_t   out_q;

	tfs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tfs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.divisor (div_divisor),
		.rsp     (div_rsp)
	);

	tfs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_sample   (s_tdata),
		.div_req     (div_req),
		.div_divisor (div_divisor),
		.div_rsp     (div_rsp),
		.res_valid   (res_valid),
		.res         (res),
		.out_free    (out_free)
	);

	// The output register can take a new result when it is empty or its
	// current beat is being taken in this cycle.
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.pressed, out_q.torque_reference,
		out_q.throttle_level, out_q.filtered_level};

endmodule

`default_nettype wire

// ===== rtl/tfs_cfg.sv =====
`default_nettype none

module tfs_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [tfs_pkg::CFG_IDX_W-1:0]        wr_index,
	input  wire logic [tfs_pkg::CFG_DATA_W-1:0]       wr_data,
	output tfs_pkg::cfg_t                             cfg
);

	tfs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bw_rise       <= 16'd16;
			cfg_q.bw_fall       <= 16'd16;
			cfg_q.thr_offset    <= 16'd0;
			cfg_q.thr_slope     <= 15'd1;
			cfg_q.thr_divisor   <= 16'd1;
			cfg_q.tq_offset     <= 16'd0;
			cfg_q.tq_slope      <= 16'd1;
			cfg_q.tq_divisor    <= 16'd1;
			cfg_q.detect_thresh <= 16'd0;
		end else if (wr_en) begin
			unique case (tfs_pkg::reg_idx_t'(wr_index))
				tfs_pkg::REG_FILTER_BW: begin
					cfg_q.bw_rise <= wr_data[15:0];
					cfg_q.bw_fall <= wr_data[31:16];
				end
				tfs_pkg::REG_THR_OFFSET:    cfg_q.thr_offset    <= wr_data[15:0];
				tfs_pkg::REG_THR_SLOPE:     cfg_q.thr_slope     <= wr_data[14:0];
				tfs_pkg::REG_THR_DIVISOR:   cfg_q.thr_divisor   <= wr_data[15:0];
				tfs_pkg::REG_TQ_OFFSET:     cfg_q.tq_offset     <= wr_data[15:0];
				tfs_pkg::REG_TQ_SLOPE:      cfg_q.tq_slope      <= wr_data[15:0];
				tfs_pkg::REG_TQ_DIVISOR:    cfg_q.tq_divisor    <= wr_data[15:0];
				tfs_pkg::REG_DETECT_THRESH: cfg_q.detect_thresh <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tfs_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// upper half of the dividend is below the divisor, so the quotient fits 16 bits.
module tfs_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tfs_pkg::div_req_t req,
	input  wire logic [15:0]       divisor,
	output tfs_pkg::div_rsp_t      rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [tfs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [15:0]                   rem_q;
	logic [15:0]                   low_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, low_q[15]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tfs_pkg::DIV_CNT_W'(tfs_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			low_q <= req.low_init;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			low_q <= {low_q[14:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = low_q;

endmodule

`default_nettype wire

// ===== rtl/tfs_seq.sv =====
`default_nettype none

// Sequencer: walks one sample through filter (skipped for a failed conversion),
// throttle and torque stages, sharing one 16x16 multiplier and the external divider.
module tfs_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tfs_pkg::cfg_t     cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [15:0]       in_sample,
	output tfs_pkg::div_req_t      div_req,
	output logic [15:0]            div_divisor,
	input  wire tfs_pkg::div_rsp_t div_rsp,
	output logic                   res_valid,
	output tfs_pkg::result_t       res,
	input  wire logic              out_free
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_F_MUL,
		S_F_LOAD,
		S_F_DIV,
		S_T_MUL,
		S_T_LOAD,
		S_T_DIV,
		S_Q_MUL,
		S_Q_LOAD,
		S_Q_DIV,
		S_FINISH
	} state_t;

	state_t      state_q;
	logic [15:0] avg_q;
	logic [15:0] sample_q;
	logic [31:0] prod_q;
	logic [15:0] divisor_q;
	logic [15:0] thr_q;
	logic [15:0] tq_q;
	logic        neg_q;

	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] product;
	logic [15:0] bw_nz;
	logic [15:0] thr_level;
	logic [15:0] tq_level;
	logic [15:0] slope_mag;
	logic [31:0] acc;
	logic [31:0] load_word;
	logic        sat_hi;
	logic [15:0] q_neg;

	assign bw_nz = tfs_pkg::nonzero16((sample_q > avg_q) ? cfg.bw_rise : cfg.bw_fall);
	assign thr_level = (avg_q > cfg.thr_offset) ? (avg_q - cfg.thr_offset) : 16'd0;
	assign tq_level  = (thr_q > cfg.tq_offset) ? (thr_q - cfg.tq_offset) : 16'd0;
	assign slope_mag = cfg.tq_slope[15] ? (16'd0 - cfg.tq_slope) : cfg.tq_slope;

	always_comb begin
		mul_a = 16'd0;
		mul_b = 16'd0;
		case (state_q)
			S_F_MUL: begin
				mul_a = bw_nz - 16'd1;
				mul_b = avg_q;
			end
			S_T_MUL: begin
				mul_a = {1'b0, cfg.thr_slope};
				mul_b = thr_level;
			end
			S_Q_MUL: begin
				mul_a = slope_mag;
				mul_b = tq_level;
			end
			default: ;
		endcase
	end

	assign product = mul_a * mul_b;

	// The filter sum cannot overflow 32 bits and its upper half stays below bw.
	assign acc       = prod_q + {16'd0, sample_q};
	assign load_word = (state_q == S_F_LOAD) ? acc : prod_q;
	// A quotient of 65536 or more saturates the scaled output of that stage.
	assign sat_hi    = prod_q[31:16] >= divisor_q;
	assign q_neg     = 16'd0 - div_rsp.quotient;

	assign div_req.start = (state_q == S_F_LOAD)
		|| ((state_q == S_T_LOAD) && !sat_hi)
		|| ((state_q == S_Q_LOAD) && !sat_hi);
	assign div_req.rem_init = load_word[31:16];
	assign div_req.low_init = load_word[15:0];
	assign div_divisor      = divisor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			avg_q   <= 16'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_sample == tfs_pkg::ADC_INVALID)
							? S_T_MUL : S_F_MUL;
					end
				end
				S_F_MUL:  state_q <= S_F_LOAD;
				S_F_LOAD: state_q <= S_F_DIV;
				S_F_DIV: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quotient;
						state_q <= S_T_MUL;
					end
				end
				S_T_MUL:  state_q <= S_T_LOAD;
				S_T_LOAD: state_q <= sat_hi ? S_Q_MUL : S_T_DIV;
				S_T_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_Q_MUL;
					end
				end
				S_Q_MUL:  state_q <= S_Q_LOAD;
				S_Q_LOAD: state_q <= sat_hi ? S_FINISH : S_Q_DIV;
				S_Q_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					sample_q <= in_sample;
				end
			end
			S_F_MUL: begin
				prod_q    <= product;
				divisor_q <= bw_nz;
			end
			S_T_MUL: begin
				prod_q    <= product;
				divisor_q <= tfs_pkg::nonzero16(cfg.thr_divisor);
			end
			S_T_LOAD: begin
				if (sat_hi) begin
					thr_q <= tfs_pkg::LEVEL_SAT;
				end
			end
			S_T_DIV: begin
				if (div_rsp.done) begin
					thr_q <= div_rsp.quotient;
				end
			end
			S_Q_MUL: begin
				prod_q    <= product;
				divisor_q <= tfs_pkg::nonzero16(cfg.tq_divisor);
				neg_q     <= cfg.tq_slope[15];
			end
			S_Q_LOAD: begin
				if (sat_hi) begin
					tq_q <= neg_q ? tfs_pkg::TORQUE_NEG_LIMIT
						: tfs_pkg::TORQUE_POS_LIMIT;
				end
			end
			S_Q_DIV: begin
				if (div_rsp.done) begin
					if (neg_q) begin
						tq_q <= (div_rsp.quotient > tfs_pkg::TORQUE_NEG_LIMIT)
							? tfs_pkg::TORQUE_NEG_LIMIT : q_neg;
					end else begin
						tq_q <= (div_rsp.quotient > tfs_pkg::TORQUE_POS_LIMIT)
							? tfs_pkg::TORQUE_POS_LIMIT : div_rsp.quotient;
					end
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res.filtered_level   = avg_q;
	assign res.throttle_level   = thr_q;
	assign res.torque_reference = tq_q;
	assign res.pressed          = thr_q > cfg.detect_thresh;

`ifndef SYNTH
	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while still busy");

	a_avg_only_from_filter: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(avg_q) |-> $past(state_q == S_F_DIV) && $past(div_rsp.done))
		else $error("average changed outside the filter division");

	a_invalid_skips_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && in_valid && (in_sample == tfs_pkg::ADC_INVALID)
		|=> (state_q == S_T_MUL))
		else $error("invalid sample entered the filter update");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/throttle_filter_scale_core_test.sv =====
module throttle_filter_scale_core_test;

	import tfs_pkg::*;

	// Generous ceiling on the run length. The slowest legal run is roughly
	// 1100 samples plus handshake stalls, and this ceiling leaves several
	// times its length as margin.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int SAMPLES_PER_PHASE = 122;
	localparam int RANDOM_PHASES = 9;
	// A little longer than one valid sample takes from acceptance to result.
	localparam int SETTLE_CYCLES = 70;

	// Scoreboard: mirrors the register file and the running average, works
	// out the result beat that each accepted sample must produce and compares
	// the output beats against those in order.
	class throttle_scoreboard;
		cfg_t regs_mirror;
		logic [15:0] average;
		result_t outstanding[$];
		int errors;

		function new();
			regs_mirror = '0;
			regs_mirror.bw_rise = 16'd16;
			regs_mirror.bw_fall = 16'd16;
			regs_mirror.thr_slope = 15'd1;
			regs_mirror.thr_divisor = 16'd1;
			regs_mirror.tq_slope = 16'd1;
			regs_mirror.tq_divisor = 16'd1;
			average = 16'd0;
			errors = 0;
		endfunction

		function int pending();
			return outstanding.size();
		endfunction

		// Bits above each register's width are simply dropped.
		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_FILTER_BW: begin
					regs_mirror.bw_rise = value[15:0];
					regs_mirror.bw_fall = value[31:16];
				end
				REG_THR_OFFSET:    regs_mirror.thr_offset = value[15:0];
				REG_THR_SLOPE:     regs_mirror.thr_slope = value[14:0];
				REG_THR_DIVISOR:   regs_mirror.thr_divisor = value[15:0];
				REG_TQ_OFFSET:     regs_mirror.tq_offset = value[15:0];
				REG_TQ_SLOPE:      regs_mirror.tq_slope = value[15:0];
				REG_TQ_DIVISOR:    regs_mirror.tq_divisor = value[15:0];
				REG_DETECT_THRESH: regs_mirror.detect_thresh = value[15:0];
				default: ;
			endcase
		endfunction

		// A zero bandwidth or divisor behaves as one.
		function logic [15:0] at_least_one(logic [15:0] v);
			return (v == 16'd0) ? 16'd1 : v;
		endfunction

		function void note_sample(logic [15:0] sample);
			logic [15:0] bw;
			logic [31:0] acc;
			logic [15:0] above_offset;
			logic [31:0] scaled;
			logic [15:0] throttle;
			logic [15:0] above_tq_offset;
			longint torque;
			result_t r;
			// The bandwidth is picked even for a failed conversion, but only
			// a good conversion moves the average.
			bw = (sample > average) ? regs_mirror.bw_rise : regs_mirror.bw_fall;
			bw = at_least_one(bw);
			if (sample != ADC_INVALID) begin
				acc = (32'(bw) - 32'd1) * 32'(average) + 32'(sample);
				average = 16'(acc / 32'(bw));
			end

			above_offset = (average > regs_mirror.thr_offset) ?
				average - regs_mirror.thr_offset : 16'd0;
			scaled = (32'(regs_mirror.thr_slope) * 32'(above_offset)) /
				32'(at_least_one(regs_mirror.thr_divisor));
			throttle = (scaled > 32'(LEVEL_SAT)) ? LEVEL_SAT : scaled[15:0];

			above_tq_offset = (throttle > regs_mirror.tq_offset) ?
				throttle - regs_mirror.tq_offset : 16'd0;
			// Signed 64-bit division truncates toward zero, as required.
			torque = (longint'($signed(regs_mirror.tq_slope)) * longint'(above_tq_offset)) /
				longint'(at_least_one(regs_mirror.tq_divisor));
			if (torque > longint'($signed(TORQUE_POS_LIMIT)))
				torque = longint'($signed(TORQUE_POS_LIMIT));
			else if (torque < longint'($signed(TORQUE_NEG_LIMIT)))
				torque = longint'($signed(TORQUE_NEG_LIMIT));

			r.filtered_level = average;
			r.throttle_level = throttle;
			r.torque_reference = torque[15:0];
			r.pressed = (throttle > regs_mirror.detect_thresh);
			outstanding.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %h got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_output(logic [55:0] beat);
			result_t want;
			result_t got;
			if (outstanding.size() == 0) begin
				$display("%0t: output beat %h with nothing outstanding, expected none",
					$time, beat);
				errors++;
				return;
			end
			want = outstanding.pop_front();
			got = result_t'(beat[48:0]);
			compare_field("filtered_level", want.filtered_level, got.filtered_level);
			compare_field("throttle_level", want.throttle_level, got.throttle_level);
			compare_field("torque_reference", want.torque_reference, got.torque_reference);
			compare_field("pressed", 16'(want.pressed), 16'(got.pressed));
			compare_field("padding", 16'd0, 16'(beat[55:49]));
		endfunction
	endclass

	// Every input of the core holds a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	throttle_scoreboard sb;
	logic [31:0] settings [8];
	logic [15:0] target_level = 16'h4000;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int unsigned cycle_count = 0;

	throttle_filter_scale_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("throttle_filter_scale_core_test: FAIL");
			$finish;
		end
	end

	// Result side. The beat is taken from the values sampled at the edge, and
	// ready is then redrawn for the next cycle according to the current
	// back-pressure level.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata);
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offers one sample, after a random number of idle cycles, and holds it
	// until the core takes the beat. The expected result is worked out at
	// acceptance, so it always sees the register values in force then.
	task automatic offer_sample(input logic [15:0] sample);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sample;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(sample);
	endtask

	// Writes all eight registers back to back. The write enable stays high
	// across the burst and drops once at the end.
	task automatic program_registers();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= settings[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), settings[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Every sample yields exactly one result, so once the last result beat
	// has been taken the core is idle; settle covers any trailing activity.
	task automatic wait_idle(input int settle);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// A 16-bit register value with random junk in the unused upper bits,
	// which the core must ignore.
	function automatic logic [31:0] with_junk(input logic [15:0] v);
		return {16'($urandom()), v};
	endfunction

	function automatic logic [15:0] pick_bandwidth();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 16'd0;
		else if (roll < 20)
			return 16'd1;
		else if (roll < 70)
			return 16'($urandom_range(16, 2));
		else if (roll < 80)
			return 16'hFFFF;
		else
			return 16'($urandom());
	endfunction

	function automatic logic [15:0] pick_extreme_or(input logic [15:0] v);
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 16'h0000;
		else if (roll < 20)
			return 16'hFFFF;
		else
			return v;
	endfunction

	// Fills the register set for one phase: both extremes first, then
	// random settings biased towards ones that keep the outputs moving.
	function automatic void choose_settings(input int phase);
		logic [15:0] slope;
		logic [15:0] divisor;
		case (phase)
			0: begin
				foreach (settings[i])
					settings[i] = 32'hFFFF_FFFF;
				settings[REG_THR_SLOPE] = 32'hFFFF_7FFF;
				settings[REG_TQ_SLOPE] = 32'hFFFF_7FFF;
			end
			1: begin
				foreach (settings[i])
					settings[i] = 32'h0000_0000;
			end
			default: begin
				settings[REG_FILTER_BW] = {pick_bandwidth(), pick_bandwidth()};
				settings[REG_THR_OFFSET] = with_junk(pick_extreme_or(
					16'($urandom_range(20000))));
				slope = 16'($urandom_range(32767, 1));
				if ($urandom_range(99) < 10)
					slope = 16'd0;
				else if ($urandom_range(99) < 10)
					slope = 16'h7FFF;
				// Often let the divisor track the slope so the throttle
				// spans its full range rather than saturating or vanishing.
				if ($urandom_range(99) < 35)
					divisor = (slope == 16'd0) ? 16'd1 : slope;
				else
					divisor = pick_extreme_or(16'($urandom_range(65535, 1)));
				settings[REG_THR_SLOPE] = {17'($urandom()), slope[14:0]};
				settings[REG_THR_DIVISOR] = with_junk(divisor);
				settings[REG_TQ_OFFSET] = with_junk(pick_extreme_or(
					16'($urandom_range(30000))));
				case ($urandom_range(3))
					0: settings[REG_TQ_SLOPE] = with_junk(16'h8000);
					1: settings[REG_TQ_SLOPE] = with_junk(16'h7FFF);
					default: settings[REG_TQ_SLOPE] = with_junk(16'($urandom()));
				endcase
				settings[REG_TQ_DIVISOR] = with_junk(pick_extreme_or(16'($urandom())));
				settings[REG_DETECT_THRESH] = with_junk(pick_extreme_or(16'($urandom())));
			end
		endcase
	endfunction

	// Samples mostly wander around a target level that jumps now and then, so
	// the average climbs and falls through both bandwidths; the rest are
	// failed conversions, rail values and wide-open noise.
	function automatic logic [15:0] next_sample();
		int roll;
		int near;
		if ($urandom_range(39) == 0) begin
			case ($urandom_range(9))
				0: target_level = 16'd0;
				1: target_level = 16'hFFFE;
				default: target_level = 16'($urandom_range(65534));
			endcase
		end
		roll = $urandom_range(99);
		if (roll < 10)
			return ADC_INVALID;
		else if (roll < 15)
			return 16'd0;
		else if (roll < 20)
			return 16'hFFFE;
		else if (roll < 80) begin
			near = int'(target_level) + int'($urandom_range(1024)) - 512;
			if (near < 0)
				near = 0;
			else if (near > 65534)
				near = 65534;
			return 16'(near);
		end else
			return 16'($urandom());
	endfunction

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under light sender gaps and heavy back-pressure.
		tx_idle_pct = 11;
		rx_idle_pct = 76;

		// Reset settings: a failed conversion before any good one, the rails,
		// and a failed conversion holding a high average.
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		offer_sample(16'hFFFE);
		offer_sample(16'hFFFE);
		offer_sample(16'hFFFF);
		offer_sample(16'h8000);
		offer_sample(16'h0000);
		wait_idle(1);

		// Zero bandwidths make the average follow the sample directly; zero
		// divisors, the largest slope and the most negative torque slope
		// drive throttle and torque into saturation. Junk sits above the width of
		// every register but the filter bandwidths.
		settings[REG_FILTER_BW] = 32'h0000_0000;
		settings[REG_THR_OFFSET] = 32'hA5A5_0000;
		settings[REG_THR_SLOPE] = 32'hFFFF_FFFF;
		settings[REG_THR_DIVISOR] = 32'h1234_0000;
		settings[REG_TQ_OFFSET] = 32'h8000_0000;
		settings[REG_TQ_SLOPE] = 32'h5A5A_8000;
		settings[REG_TQ_DIVISOR] = 32'hFFFF_0000;
		settings[REG_DETECT_THRESH] = 32'h0001_FFFE;
		program_registers();
		offer_sample(16'hFFFE);
		offer_sample(16'h0001);
		offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		offer_sample(16'h8000);
		wait_idle(1);

		// Instant rise against a very slow fall, with the torque offset and
		// the threshold at their maxima.
		settings[REG_FILTER_BW] = 32'hFFFF_0001;
		settings[REG_THR_OFFSET] = 32'h0000_0064;
		settings[REG_THR_SLOPE] = 32'h0000_0003;
		settings[REG_THR_DIVISOR] = 32'h0000_0002;
		settings[REG_TQ_OFFSET] = 32'h0000_FFFF;
		settings[REG_TQ_SLOPE] = 32'h0000_7FFF;
		settings[REG_TQ_DIVISOR] = 32'h0000_0001;
		settings[REG_DETECT_THRESH] = 32'h0000_FFFF;
		program_registers();
		offer_sample(16'hFFFE);
		offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		offer_sample(16'h0064);
		offer_sample(16'h0065);
		wait_idle(1);

		// The other way round: a very slow rise and an instant fall, with the
		// largest torque divisor.
		settings[REG_FILTER_BW] = 32'h0001_FFFF;
		settings[REG_THR_OFFSET] = 32'h0000_0000;
		settings[REG_THR_SLOPE] = 32'h0000_0001;
		settings[REG_THR_DIVISOR] = 32'h0000_0001;
		settings[REG_TQ_OFFSET] = 32'h0000_0000;
		settings[REG_TQ_SLOPE] = 32'h0000_7FFF;
		settings[REG_TQ_DIVISOR] = 32'h0000_FFFF;
		settings[REG_DETECT_THRESH] = 32'h0000_0000;
		program_registers();
		offer_sample(16'h0000);
		offer_sample(16'hFFFE);
		offer_sample(16'h5555);
		offer_sample(16'hAAAA);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		wait_idle(1);

		// Random phases: a third with heavy back-pressure, a third with a
		// slow sender, and a third running flat out.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 3) begin
				tx_idle_pct = 11;
				rx_idle_pct = 76;
			end else if (p < 6) begin
				tx_idle_pct = 76;
				rx_idle_pct = 11;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			choose_settings(p);
			program_registers();
			for (int k = 0; k < SAMPLES_PER_PHASE; k++)
				offer_sample(next_sample());
			wait_idle(1);
		end

		wait_idle(SETTLE_CYCLES);
		if (sb.errors == 0)
			$display("throttle_filter_scale_core_test: PASS");
		else
			$display("throttle_filter_scale_core_test: FAIL");
		$finish;
	end

endmodule

// ===== throttle_filter_scale_core.f =====
rtl/tfs_pkg.sv
rtl/tfs_cfg.sv
rtl/tfs_div.sv
rtl/tfs_seq.sv
rtl/throttle_filter_scale_core.sv
tb/sv/throttle_filter_scale_core_test.sv
